/* sv/ssm_pkg.sv */
// Shared constants, command codes and link types for the substring search block.
package ssm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int POS_W       = 16;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_PATTERN = 2'd1;
  localparam logic [1:0] FUNC_TEXT    = 2'd2;
  localparam logic [1:0] FUNC_FINISH  = 2'd3;

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_PATTERN,
    CMD_TEXT,
    CMD_FINISH,
    CMD_OVERFLOW
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_link_t;

endpackage

/* sv/ssm_if.sv */
// Handshake channels for input words and result words.
interface ssm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface ssm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic        found;
  logic        overflow;

  modport source (output valid, output position, output found, output overflow, input ready);
  modport sink (input valid, input position, input found, input overflow, output ready);
endinterface

/* sv/substring_first_match.sv */
// A finish word passes through the command queue, and its result is then held in the result register.
// Throughput: one word per cycle while the queue has room, set by the parallel window compare.
// A finish word waits in the queue only while the previous result is still untaken.
// Reset clears the pattern length, text counter, match and overflow flags and the queue.
// The pattern store and text window hold no reset value; they are masked until written.
// Top level of the first-match substring search.
module substring_first_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssm_in_if.sink     in_i,
  ssm_out_if.source  out_o
);

  ssm_pkg::q_link_t push, pop;
  logic             q_full, pop_ready;

  ssm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  ssm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .pop_o       (pop),
    .pop_ready_i (pop_ready)
  );

  ssm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

/* sv/ssm_front.sv */
// Front end: accepts input words and classifies them into commands for the queue.
module ssm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssm_in_if.sink            in_i,
  input  logic              q_full_i,
  output ssm_pkg::q_link_t  push_o
);

  logic [ssm_pkg::LEN_W-1:0] plen_q, plen_d;
  logic                      text_begun_q, text_begun_d;
  logic                      accept;
  ssm_pkg::cmd_e             op;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // Pattern bytes that arrive after text or beyond the store only raise overflow.
  always_comb begin
    unique case (in_i.func)
      ssm_pkg::FUNC_CLEAR:   op = ssm_pkg::CMD_CLEAR;
      ssm_pkg::FUNC_PATTERN: begin
        if (text_begun_q || plen_q == ssm_pkg::LEN_W'(ssm_pkg::MAX_PATTERN)) begin
          op = ssm_pkg::CMD_OVERFLOW;
        end else begin
          op = ssm_pkg::CMD_PATTERN;
        end
      end
      ssm_pkg::FUNC_TEXT:    op = ssm_pkg::CMD_TEXT;
      ssm_pkg::FUNC_FINISH:  op = ssm_pkg::CMD_FINISH;
      default:               op = ssm_pkg::CMD_FINISH;
    endcase
  end

  always_comb begin
    plen_d       = plen_q;
    text_begun_d = text_begun_q;
    if (accept) begin
      case (op)
        ssm_pkg::CMD_CLEAR: begin
          plen_d       = '0;
          text_begun_d = 1'b0;
        end
        ssm_pkg::CMD_PATTERN: plen_d = plen_q + ssm_pkg::LEN_W'(1);
        ssm_pkg::CMD_TEXT:    text_begun_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q       <= '0;
      text_begun_q <= 1'b0;
    end else begin
      plen_q       <= plen_d;
      text_begun_q <= text_begun_d;
    end
  end

  assign push_o.valid    = in_i.valid;
  assign push_o.cmd.op   = op;
  assign push_o.cmd.data = in_i.data_byte;

endmodule

/* sv/ssm_queue.sv */
// Short command queue between the front end and the execution back end.
module ssm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssm_pkg::q_link_t  push_i,
  output logic              full_o,
  output ssm_pkg::q_link_t  pop_o,
  input  logic              pop_ready_i
);

  ssm_pkg::cmd_t              mem_q [ssm_pkg::QUEUE_DEPTH];
  logic [ssm_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ssm_pkg::QCNT_W-1:0] cnt_q;
  logic                       do_push, do_pop;

  assign full_o  = cnt_q == ssm_pkg::QCNT_W'(ssm_pkg::QUEUE_DEPTH);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_o.valid && pop_ready_i;

  assign pop_o.valid = cnt_q != '0;
  assign pop_o.cmd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == ssm_pkg::QPTR_W'(ssm_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + ssm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ssm_pkg::QPTR_W'(ssm_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + ssm_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + ssm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - ssm_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* sv/ssm_back.sv */
// Back end: pattern store, text window compare, match tracking and the result register.
module ssm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssm_pkg::q_link_t  pop_i,
  output logic              pop_ready_o,
  ssm_out_if.source         out_o
);

  localparam int MP = ssm_pkg::MAX_PATTERN;
  localparam int CW = ssm_pkg::COUNT_WIDTH;

  // The pattern is kept right aligned so that its last byte sits beside the newest text byte.
  logic [7:0]                pat_q    [MP];
  logic [7:0]                window_q [MP];
  logic [7:0]                window_nx[MP];
  logic [MP-1:0]             pmask_q;
  logic [MP-1:0]             hit;
  logic [ssm_pkg::LEN_W-1:0] len_q;
  logic [CW-1:0]             count_q, count_inc, mstart_q;
  logic                      mseen_q, ovf_q;
  logic                      out_valid_q;
  logic [ssm_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      found_q, found_d, ovf_out_q;
  logic                      do_pop, count_full, match_now, finish_pop;

  assign pop_ready_o = (pop_i.cmd.op != ssm_pkg::CMD_FINISH) || !out_valid_q || out_o.ready;
  assign do_pop      = pop_i.valid && pop_ready_o;
  assign finish_pop  = do_pop && pop_i.cmd.op == ssm_pkg::CMD_FINISH;

  assign count_full = count_q == '1;
  assign count_inc  = count_q + CW'(1);

  always_comb begin
    for (int i = 0; i < MP; i++) begin
      window_nx[i] = (i == MP - 1) ? pop_i.cmd.data : window_q[(i + 1) % MP];
      hit[i]       = !pmask_q[i] || (window_nx[i] == pat_q[i]);
    end
  end

  assign match_now = !mseen_q && len_q != '0 && (33'(len_q) <= 33'(count_inc)) && (&hit);

  always_comb begin
    if (len_q == '0) begin
      pos_d   = ssm_pkg::POS_W'(1);
      found_d = 1'b1;
    end else if (mseen_q) begin
      pos_d   = (33'(mstart_q) > 33'(ssm_pkg::POS_MAX)) ? '1 : ssm_pkg::POS_W'(mstart_q);
      found_d = 1'b1;
    end else begin
      pos_d   = '0;
      found_d = 1'b0;
    end
  end

  // Store and window carry no reset; only entries covered by the mask are ever compared.
  always_ff @(posedge clk_i) begin
    if (do_pop && pop_i.cmd.op == ssm_pkg::CMD_PATTERN) begin
      for (int i = 0; i < MP - 1; i++) begin
        pat_q[i] <= pat_q[i + 1];
      end
      pat_q[MP-1] <= pop_i.cmd.data;
    end
    if (do_pop && pop_i.cmd.op == ssm_pkg::CMD_TEXT && !count_full) begin
      for (int i = 0; i < MP; i++) begin
        window_q[i] <= window_nx[i];
      end
    end
    if (finish_pop) begin
      pos_q     <= pos_d;
      found_q   <= found_d;
      ovf_out_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmask_q  <= '0;
      len_q    <= '0;
      count_q  <= '0;
      mstart_q <= '0;
      mseen_q  <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (do_pop) begin
      unique case (pop_i.cmd.op)
        ssm_pkg::CMD_CLEAR: begin
          pmask_q  <= '0;
          len_q    <= '0;
          count_q  <= '0;
          mstart_q <= '0;
          mseen_q  <= 1'b0;
          ovf_q    <= 1'b0;
        end
        ssm_pkg::CMD_PATTERN: begin
          pmask_q <= {1'b1, pmask_q[MP-1:1]};
          len_q   <= len_q + ssm_pkg::LEN_W'(1);
        end
        ssm_pkg::CMD_TEXT: begin
          if (count_full) begin
            ovf_q <= 1'b1;
          end else begin
            count_q <= count_inc;
            if (match_now) begin
              mseen_q  <= 1'b1;
              mstart_q <= count_inc - CW'(len_q) + CW'(1);
            end
          end
        end
        ssm_pkg::CMD_OVERFLOW: ovf_q <= 1'b1;
        ssm_pkg::CMD_FINISH: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_pop) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.position = pos_q;
  assign out_o.found    = found_q;
  assign out_o.overflow = ovf_out_q;

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> pos_q == '0)
    else $error("result without a match carries a nonzero position");

  a_match_needs_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mseen_q |-> len_q != '0)
    else $error("match recorded with an empty pattern");

  a_match_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mseen_q |-> (mstart_q != '0 && mstart_q <= count_q))
    else $error("match start lies outside the text seen so far");

endmodule
